// ===== rtl/core/wtoi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtoi_pkg
// Shared types and constants of the wavetable oscillator with linear
// interpolation: table geometry, fixed-point formats and command codes.
// ----------------------------------------------------------------------------
package wtoi_pkg;

    // Table geometry and number formats.
    localparam int TABLE_DEPTH     = 2048;
    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_FRAC_BITS = 21;

    localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
    localparam int PHASE_BITS = ADDR_BITS + PHASE_FRAC_BITS;
    localparam int MEM_ADDR_BITS = ADDR_BITS + 1;
    localparam int MEM_DEPTH  = 2 * TABLE_DEPTH;

    // Field and register widths of the ports.
    localparam int MODE_BITS      = 2;
    localparam int INDEX_BITS     = 11;
    localparam int STEP_BITS      = 32;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Datapath widths: difference of two samples, interpolation product and
    // gain product.
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + PHASE_FRAC_BITS + 1;
    localparam int SCALED_BITS = DIFF_BITS + GAIN_BITS + 1;

    // Saturation limits of the output sample.
    localparam logic signed [SCALED_BITS-1:0] OUT_MAX =
        SCALED_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SCALED_BITS-1:0] OUT_MIN =
        SCALED_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Command queue depth (a power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN       = CFG_INDEX_BITS'(1);

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(32768);

    // Command codes carried by the mode field.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_SAMPLE    = 2'd0,
        MODE_WRITE     = 2'd1,
        MODE_SWAP      = 2'd2,
        MODE_PHASE_RST = 2'd3
    } mode_t;

    // One classified command as it travels from the front end to the back end.
    typedef struct packed {
        mode_t                          op;
        logic                           in_range;
        logic [INDEX_BITS-1:0]          idx;
        logic signed [SAMPLE_BITS-1:0]  value;
    } cmd_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_J,
        ST_INTERP,
        ST_SCALE,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/wtoi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtoi_front
// Accepts requests, decodes the mode, checks the entry position against the
// table depth and holds the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module wtoi_front (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [wtoi_pkg::MODE_BITS-1:0]         s_mode,
    input  wire logic [wtoi_pkg::INDEX_BITS-1:0]        s_entry_index,
    input  wire logic signed [wtoi_pkg::SAMPLE_BITS-1:0] s_entry_value,
    output logic                                        cmd_valid,
    output wtoi_pkg::cmd_t                              cmd,
    input  wire logic                                   cmd_pop
);
    import wtoi_pkg::*;

    cmd_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;
    cmd_t                 cmd_in;
    logic                 push;
    logic                 pop;

    // Classify the incoming request.
    always_comb begin
        cmd_in.op       = mode_t'(s_mode);
        cmd_in.in_range = (32'(s_entry_index) < 32'(TABLE_DEPTH));
        cmd_in.idx      = s_entry_index;
        cmd_in.value    = s_entry_value;
    end

    assign s_ready   = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_pop && cmd_valid;

    // Queue pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_BITS+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/wtoi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtoi_back
// Executes queued commands: keeps the phase and bank state, owns the table
// memory, and runs the read, interpolate, scale and output sequence.
// ----------------------------------------------------------------------------
module wtoi_back (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cmd_valid,
    input  wire wtoi_pkg::cmd_t                          cmd,
    output logic                                         cmd_pop,
    input  wire logic [wtoi_pkg::STEP_BITS-1:0]          phase_step,
    input  wire logic [wtoi_pkg::GAIN_BITS-1:0]          gain,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [wtoi_pkg::SAMPLE_BITS-1:0]      m_sample_out
);
    import wtoi_pkg::*;

    // Both banks share one memory; the top address bit selects the bank.
    logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_rd_reg;
    logic [MEM_ADDR_BITS-1:0]      rd_addr;
    logic [MEM_ADDR_BITS-1:0]      wr_addr;
    logic                          mem_we;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [PHASE_BITS-1:0]     phase_reg;
    logic [PHASE_BITS-1:0]     phase_next;
    logic                      active_reg;
    logic                      active_next;
    logic                      pending_reg;
    logic                      pending_next;
    logic                      start;
    logic                      out_load;

    logic [ADDR_BITS-1:0]              i_reg;
    logic [PHASE_FRAC_BITS-1:0]        f_reg;
    logic signed [SAMPLE_BITS-1:0]     ti_reg;
    logic signed [PROD_BITS-1:0]       prod_reg;
    logic signed [SCALED_BITS-1:0]     scaled_reg;
    logic                              m_valid_reg;
    logic signed [SAMPLE_BITS-1:0]     m_sample_reg;

    logic signed [DIFF_BITS-1:0]       diff;
    logic signed [PHASE_FRAC_BITS:0]   f_s;
    logic signed [PROD_BITS-1:0]       interp_full;
    logic signed [DIFF_BITS-1:0]       interp_s;
    logic signed [GAIN_BITS:0]         gain_s;
    logic signed [SCALED_BITS-1:0]     y_full;

    assign wr_addr = {~active_reg, ADDR_BITS'(cmd.idx)};

    // Sequencer: next state, command execution and memory addressing.
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        cmd_pop      = 1'b0;
        mem_we       = 1'b0;
        start        = 1'b0;
        out_load     = 1'b0;
        rd_addr      = {active_reg, i_reg + ADDR_BITS'(1)};
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        MODE_WRITE: begin
                            mem_we       = cmd.in_range;
                            pending_next = 1'b0;
                        end
                        MODE_SWAP: begin
                            pending_next = 1'b1;
                        end
                        MODE_PHASE_RST: begin
                            phase_next = '0;
                        end
                        MODE_SAMPLE: begin
                            // Complete a pending swap, then read the lower entry.
                            active_next  = active_reg ^ pending_reg;
                            pending_next = 1'b0;
                            rd_addr      = {active_next,
                                            phase_reg[PHASE_BITS-1 -: ADDR_BITS]};
                            phase_next   = phase_reg + PHASE_BITS'(phase_step);
                            start        = 1'b1;
                            state_next   = ST_READ_J;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ_J: begin
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            active_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
        end
    end

    // Table memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= cmd.value;
        end
        mem_rd_reg <= mem[rd_addr];
    end

    // Interpolation arithmetic: s = T[i] + floor((T[j] - T[i]) * f / 2^F).
    assign diff        = DIFF_BITS'(mem_rd_reg) - DIFF_BITS'(ti_reg);
    assign f_s         = $signed({1'b0, f_reg});
    assign interp_full = (prod_reg >>> PHASE_FRAC_BITS) + PROD_BITS'(ti_reg);
    assign interp_s    = $signed(interp_full[DIFF_BITS-1:0]);
    assign gain_s      = $signed({1'b0, gain});
    assign y_full      = scaled_reg >>> GAIN_FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (start) begin
            i_reg <= phase_reg[PHASE_BITS-1 -: ADDR_BITS];
            f_reg <= phase_reg[PHASE_FRAC_BITS-1:0];
        end
        if (state_reg == ST_READ_J) begin
            ti_reg <= mem_rd_reg;
        end
        if (state_reg == ST_INTERP) begin
            prod_reg <= diff * f_s;
        end
        if (state_reg == ST_SCALE) begin
            scaled_reg <= interp_s * gain_s;
        end
    end

    // Output register with saturation to the sample range.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (y_full > OUT_MAX) begin
                m_sample_reg <= OUT_MAX[SAMPLE_BITS-1:0];
            end else if (y_full < OUT_MIN) begin
                m_sample_reg <= OUT_MIN[SAMPLE_BITS-1:0];
            end else begin
                m_sample_reg <= y_full[SAMPLE_BITS-1:0];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

endmodule
`default_nettype wire

// ===== rtl/core/wavetable_oscillator_interp_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wavetable_oscillator_interp_unit
// Wavetable oscillator with linear interpolation and a double-buffered table.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                               Handshake
//  --------  ----------------------------------  -----------------------------
//  request   s_mode, s_entry_index, s_entry_value s_valid / s_ready
//  result    m_sample_out                        m_valid / m_ready
//  config    cfg_index, cfg_wdata                cfg_we, no wait
//
//  A sample request runs through the back-end states in order: two reads through
//  the single table memory port, the interpolation multiply, the gain multiply
//  and the output load. Table writes, swap and phase reset requests are executed
//  straight from the idle state. The two-entry request queue keeps accepting,
//  until it is full, while the back end works or waits on a stalled result. Reset
//  is synchronous and active low; the table contents are not cleared by reset.
//
module wavetable_oscillator_interp_unit (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [wtoi_pkg::MODE_BITS-1:0]          s_mode,
    input  wire logic [wtoi_pkg::INDEX_BITS-1:0]         s_entry_index,
    input  wire logic signed [wtoi_pkg::SAMPLE_BITS-1:0] s_entry_value,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [wtoi_pkg::SAMPLE_BITS-1:0]      m_sample_out,
    input  wire logic                                    cfg_we,
    input  wire logic [wtoi_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [wtoi_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);
    import wtoi_pkg::*;

    logic [STEP_BITS-1:0] phase_step_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic                 cmd_valid;
    cmd_t                 cmd;
    logic                 cmd_pop;

    // Configuration registers; unused indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            gain_reg       <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PHASE_STEP: phase_step_reg <= STEP_BITS'(cfg_wdata);
                CFG_GAIN:       gain_reg       <= cfg_wdata[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    wtoi_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    wtoi_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .phase_step   (phase_step_reg),
        .gain         (gain_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

endmodule
`default_nettype wire

// ===== tb/wavetable_oscillator_interp_unit_test.sv =====
// ----------------------------------------------------------------------------
// Wavetable oscillator interpolation unit test
// Fills both table banks, then sends directed and random requests of all
// four modes across several phase step and gain settings. Back-pressure
// and idle gaps are random on both channels. A scoreboard predicts every
// sample from its own copy of the tables, phase and registers, and compares
// each result as it is accepted.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wtoi_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    // Covers the two-entry queue and the back-end sequence, with margin.
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_COUNT  = 11;
    localparam int PHASE_ITEMS  = 100;

    // Register indexes that the block does not implement.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = CFG_INDEX_BITS'(3);

    localparam longint FRAC_ONE = longint'(1) <<< PHASE_FRAC_BITS;
    localparam longint SMP_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN  = -SMP_MAX - 1;

    // Predicts each sample and holds the samples still to come.
    class sample_scoreboard;
        logic signed [SAMPLE_BITS-1:0] entries [MEM_DEPTH];
        bit                            active;
        bit                            swap_pend;
        logic [PHASE_BITS-1:0]         phase;
        logic [STEP_BITS-1:0]          step;
        logic [GAIN_BITS-1:0]          gain;
        logic signed [SAMPLE_BITS-1:0] samples_due [$];
        int                            mismatches;
        int                            results_seen;

        function new();
            active       = 1'b0;
            swap_pend    = 1'b0;
            phase        = '0;
            step         = '0;
            gain         = GAIN_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_config(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_PHASE_STEP: step = data[STEP_BITS-1:0];
                CFG_GAIN:       gain = data[GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Completes a pending swap, interpolates at the phase and scales.
        function logic signed [SAMPLE_BITS-1:0] next_sample();
            logic [ADDR_BITS-1:0]       i;
            logic [ADDR_BITS-1:0]       j;
            logic [PHASE_FRAC_BITS-1:0] f;
            longint                     acc;
            longint                     s;
            longint                     y;
            if (swap_pend) begin
                active    = ~active;
                swap_pend = 1'b0;
            end
            i   = phase[PHASE_BITS-1:PHASE_FRAC_BITS];
            j   = i + ADDR_BITS'(1);
            f   = phase[PHASE_FRAC_BITS-1:0];
            acc = longint'(entries[{active, i}]) * (FRAC_ONE - longint'(f))
                + longint'(entries[{active, j}]) * longint'(f);
            s   = acc >>> PHASE_FRAC_BITS;
            y   = (s * longint'(gain)) >>> GAIN_FRAC_BITS;
            if (y > SMP_MAX)
                y = SMP_MAX;
            if (y < SMP_MIN)
                y = SMP_MIN;
            phase = phase + step;
            return SAMPLE_BITS'(y);
        endfunction

        function void note_request(mode_t op, logic [INDEX_BITS-1:0] idx,
                                   logic signed [SAMPLE_BITS-1:0] val);
            case (op)
                MODE_WRITE: begin
                    // The write goes to the shadow bank and cancels a swap.
                    entries[{~active, idx}] = val;
                    swap_pend = 1'b0;
                end
                MODE_SWAP:      swap_pend = 1'b1;
                MODE_PHASE_RST: phase = '0;
                default:        samples_due.push_back(next_sample());
            endcase
        endfunction

        function int pending();
            return samples_due.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic signed [SAMPLE_BITS-1:0] got);
            logic signed [SAMPLE_BITS-1:0] want;
            results_seen++;
            if (samples_due.size() == 0) begin
                report($sformatf("result %0d: sample_out %0d with none expected",
                                 results_seen, got));
            end else begin
                want = samples_due.pop_front();
                if (got !== want)
                    report($sformatf("result %0d: sample_out %0d, expected %0d",
                                     results_seen, got, want));
            end
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [MODE_BITS-1:0]          s_mode;
    logic [INDEX_BITS-1:0]         s_entry_index;
    logic signed [SAMPLE_BITS-1:0] s_entry_value;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;
    logic                          cfg_we;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata;

    sample_scoreboard sb;
    bit               calm;
    bit               press_go;
    int               cycles;

    wavetable_oscillator_interp_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Table values lean toward the extremes.
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return SAMPLE_BITS'($urandom_range(15)) - 16'sd8;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return 32'($urandom_range(4095));
            3:       return {11'($urandom_range(3)), 21'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return GAIN_RESET;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(32768));
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one request, with a random gap before it.
    task automatic send_request(mode_t op, logic [INDEX_BITS-1:0] idx,
                                logic signed [SAMPLE_BITS-1:0] val);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while (!calm && $urandom_range(99) < IDLE_PCT);
        end
        s_valid       <= 1'b1;
        s_mode        <= op;
        s_entry_index <= idx;
        s_entry_value <= val;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_request(op, idx, val);
    endtask

    // Sends a request whose index and value the block should ignore.
    task automatic send_command(mode_t op);
        send_request(op, INDEX_BITS'($urandom), SAMPLE_BITS'($urandom));
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_config(idx, data);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [STEP_BITS-1:0] step, logic [GAIN_BITS-1:0] gain);
        write_register(CFG_PHASE_STEP, step);
        write_register(CFG_GAIN, {16'($urandom), gain});
        write_register(CFG_SPARE_2, $urandom);
        write_register(CFG_SPARE_3, $urandom);
    endtask

    // Lets every outstanding sample and queued command clear the block.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic fill_shadow_bank();
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_request(MODE_WRITE, INDEX_BITS'(k), rand_sample());
    endtask

    // Result side: random back-pressure, one long hold, and checking.
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_sample_out);
            if (press_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL wavetable_oscillator_interp_unit");
        $finish;
    end

    // Request side and the sequence of phases.
    initial begin : stimulus
        mode_t op;
        int    r;
        sb            = new();
        calm          = 1'b0;
        press_go      = 1'b0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_mode        <= MODE_SAMPLE;
        s_entry_index <= '0;
        s_entry_value <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_PHASE_STEP;
        cfg_wdata     <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Preload: fill bank b, swap it in with one sample, then fill bank a,
        // so that no sample ever reads an unwritten entry.
        fill_shadow_bank();
        send_command(MODE_SWAP);
        send_command(MODE_SAMPLE);
        fill_shadow_bank();
        drain();

        // Directed part. A step of 2047.5 entries makes the second sample
        // interpolate between the last entry and entry zero.
        configure(32'hFFF0_0000, GAIN_RESET);
        send_command(MODE_PHASE_RST);
        send_request(MODE_WRITE, 11'd0, 16'sh8000);
        send_request(MODE_WRITE, 11'd2047, 16'sh7FFF);
        send_request(MODE_WRITE, 11'd1, 16'sh7FFF);
        send_command(MODE_SWAP);
        // A repeated swap request stays a single swap.
        send_command(MODE_SWAP);
        send_command(MODE_SAMPLE);
        send_command(MODE_SAMPLE);
        send_command(MODE_SAMPLE);
        send_command(MODE_PHASE_RST);
        send_command(MODE_SAMPLE);
        // A write while a swap is pending cancels the swap.
        send_command(MODE_SWAP);
        send_request(MODE_WRITE, 11'd5, 16'sh0000);
        send_command(MODE_SAMPLE);
        send_command(MODE_SAMPLE);
        drain();

        // Gain above unity on full-scale entries drives the output into
        // saturation at both ends.
        configure(32'h0010_0000, 16'hFFFF);
        send_command(MODE_PHASE_RST);
        send_command(MODE_SAMPLE);
        send_command(MODE_SAMPLE);
        send_command(MODE_SAMPLE);
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       configure(32'hFFFF_FFFF, 16'd0);
                1:       configure(32'h0, 16'hFFFF);
                2:       configure(32'h1, GAIN_RESET);
                default: configure(pick_step(), pick_gain());
            endcase
            calm     = (ph == 4);
            press_go = press_go || (ph == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 55)
                    op = MODE_SAMPLE;
                else if (r < 85)
                    op = MODE_WRITE;
                else if (r < 93)
                    op = MODE_SWAP;
                else
                    op = MODE_PHASE_RST;
                send_request(op, INDEX_BITS'($urandom), rand_sample());
            end
            drain();
        end
        calm = 1'b0;

        if (sb.mismatches == 0)
            $display("PASS wavetable_oscillator_interp_unit");
        else
            $display("FAIL wavetable_oscillator_interp_unit");
        $finish;
    end

endmodule
